/* rtl/u16u8_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and byte encoding functions for the utf-16 to
// utf-8 encoder
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned CpW   = 21;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 2;

  localparam logic [UnitW-1:0] SurrMask = 16'hFC00;
  localparam logic [UnitW-1:0] HighSurr = 16'hD800;
  localparam logic [UnitW-1:0] LowSurr  = 16'hDC00;
  localparam logic [CpW-1:0]   SuppBase = 21'h10000;

  // request on the input channel
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             text_end;
  } in_item_t;

  // request on the output channel
  typedef struct packed {
    logic [ByteW-1:0] utf8_byte;
    logic             run_last;
  } out_item_t;

  // work handed from front to back: one or two code points to encode
  typedef struct packed {
    logic [CpW-1:0]   cp_a;
    logic             has_b;
    logic [UnitW-1:0] cp_b;
  } job_t;

  // index of the last byte of the sequence for a code point
  function automatic logic [IdxW-1:0] last_idx(input logic [CpW-1:0] cp);
    logic [IdxW-1:0] r;
    if (cp[CpW-1:7] == '0) begin
      r = 2'd0;
    end else if (cp[CpW-1:11] == '0) begin
      r = 2'd1;
    end else if (cp[CpW-1:16] == '0) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // byte number idx of the sequence whose last index is lst
  function automatic logic [ByteW-1:0] enc_byte(input logic [CpW-1:0] cp,
                                                input logic [IdxW-1:0] lst,
                                                input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] b;
    logic [IdxW-1:0]  from_end;
    from_end = lst - idx;
    if (idx == 2'd0) begin
      case (lst)
        2'd0:    b = {1'b0, cp[6:0]};
        2'd1:    b = {3'b110, cp[10:6]};
        2'd2:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (from_end)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/u16u8_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, pairs surrogates and pushes encode jobs
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire u16u8_pkg::in_item_t in_item_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output u16u8_pkg::job_t         job_o
);

  logic                          held_q, held_d;
  logic [u16u8_pkg::UnitW-1:0]   held_unit_q, held_unit_d;
  logic                          accept;
  logic                          is_high, is_low;
  logic [u16u8_pkg::UnitW-1:0]   u;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign u          = in_item_i.code_unit;
  assign is_high    = (u & u16u8_pkg::SurrMask) == u16u8_pkg::HighSurr;
  assign is_low     = (u & u16u8_pkg::SurrMask) == u16u8_pkg::LowSurr;

  always_comb begin
    held_d      = held_q;
    held_unit_d = held_unit_q;
    push_o      = 1'b0;
    job_o.cp_a  = {5'b0, u};
    job_o.has_b = 1'b0;
    job_o.cp_b  = u;
    if (accept) begin
      held_d = 1'b0;
      push_o = 1'b1;
      if (held_q) begin
        if (is_low) begin
          // surrogate pair to one supplementary code point
          job_o.cp_a = u16u8_pkg::SuppBase + {1'b0, held_unit_q[9:0], u[9:0]};
        end else begin
          job_o.cp_a = {5'b0, held_unit_q};
          if (is_high && !in_item_i.text_end) begin
            held_d      = 1'b1;
            held_unit_d = u;
          end else begin
            job_o.has_b = 1'b1;
          end
        end
      end else if (is_high && !in_item_i.text_end) begin
        held_d      = 1'b1;
        held_unit_d = u;
        push_o      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_unit_q <= '0;
    end else begin
      held_q      <= held_d;
      held_unit_q <= held_unit_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/u16u8_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire u16u8_pkg::job_t job_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 head_valid_o,
  output u16u8_pkg::job_t      head_o
);

  u16u8_pkg::job_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_pop;

  assign full_o       = count_q == 2'd2;
  assign head_valid_o = count_q != 2'd0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/u16u8_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// walks each job one byte per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire u16u8_pkg::job_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output u16u8_pkg::out_item_t out_item_o
);

  logic                        seg_q, seg_d;
  logic [u16u8_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  u16u8_pkg::out_item_t        out_q, out_d;
  logic                        load;
  logic [u16u8_pkg::CpW-1:0]   cur_cp;
  logic [u16u8_pkg::IdxW-1:0]  lst;
  logic                        seg_end, job_end;

  assign cur_cp  = seg_q ? {5'b0, head_i.cp_b} : head_i.cp_a;
  assign lst     = u16u8_pkg::last_idx(cur_cp);
  assign seg_end = idx_q == lst;
  assign job_end = seg_end & (seg_q | ~head_i.has_b);
  assign load    = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o   = load & job_end;

  always_comb begin
    seg_d       = seg_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = load | (out_valid_q & out_stall_i);
    if (load) begin
      out_d.utf8_byte = u16u8_pkg::enc_byte(cur_cp, lst, idx_q);
      out_d.run_last  = job_end;
      if (seg_end) begin
        idx_d = '0;
        seg_d = ~job_end;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/utf16_to_utf8_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// streaming utf-16 code unit to utf-8 byte encoder
// ----------------------------------------------------------------------------
// One request in is one utf-16 code unit, one request out is one utf-8 byte;
// run_last marks the final byte of each encode job. A high surrogate is
// held until the next unit: a following low surrogate makes a four-byte
// sequence, anything else first flushes the held unit as three bytes of its
// own value. text_end on a unit never leaves anything held. The output side
// produces one byte per cycle unless out_stall_i holds it; a unit causes as
// many bytes as its job holds (none for a held surrogate, 1 to 6 otherwise).
// The front part takes a unit in every cycle while the two-entry job queue
// has room, so short bursts are absorbed without stalling the sender. Each
// job is registered in the queue, and its bytes are then registered in the
// output register one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_encoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel: code units
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire u16u8_pkg::in_item_t in_item_i,
  // output channel: encoded bytes
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output u16u8_pkg::out_item_t     out_item_o
);

  // front to queue
  logic            push;
  u16u8_pkg::job_t push_job;
  logic            q_full;
  // queue to back
  logic            head_valid;
  u16u8_pkg::job_t head_job;
  logic            pop;

  // front: surrogate pairing, one job per unit that produces bytes
  u16u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // decoupling queue so the sender is not held up by a multi-byte job
  u16u8_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  // back: byte walker feeding the registered output
  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire
